>>> rtl/bdlp_pkg.sv
// Shared types and constants for the button debounce / long-press block.
// No dependencies; every other file of the block but bdlp_in_if imports this package.
package bdlp_pkg;

  // Default structural widths
  localparam int unsigned HOLD_WIDTH_DEF  = 32;
  localparam int unsigned QUIET_WIDTH_DEF = 16;

  // Field and register widths
  localparam int unsigned EVENT_W     = 2;
  localparam int unsigned HOLD_OUT_W  = 32;
  localparam int unsigned DEBOUNCE_W  = 16;
  localparam int unsigned LONG_W      = 32;
  localparam int unsigned EDGE_W      = 2;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 32;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EDGE_MODE  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_LOW = 2'd3;

  // Configuration reset values
  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RST   = 16'd50;
  localparam logic [LONG_W-1:0]     LONG_PRESS_RST = 32'd1000;
  localparam logic [EDGE_W-1:0]     EDGE_MODE_RST  = 2'd0;
  localparam logic                  ACTIVE_LOW_RST = 1'b1;

  // Retrigger edge selection
  localparam logic [EDGE_W-1:0] EDGE_RISE = 2'd0;
  localparam logic [EDGE_W-1:0] EDGE_FALL = 2'd1;

  typedef enum logic [EVENT_W-1:0] {
    EV_PRESSED  = 2'd0,
    EV_RELEASED = 2'd1,
    EV_LONG     = 2'd2
  } event_e;

  typedef struct packed {
    event_e                  ev;
    logic [HOLD_OUT_W-1:0]   hold;
  } res_t;

endpackage

>>> rtl/bdlp_in_if.sv
// Input channel: one pin sample per beat, valid/ready handshake.
// No dependencies.
interface bdlp_in_if;
  logic valid;
  logic ready;
  logic pin_level;

  modport source (output valid, output pin_level, input ready);
  modport sink   (input valid, input pin_level, output ready);
endinterface

>>> rtl/bdlp_out_if.sv
// Result channel: one button event per beat, valid/ready handshake.
// Depends on bdlp_pkg for the field widths.
interface bdlp_out_if;
  import bdlp_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [EVENT_W-1:0]    event_res;
  logic [HOLD_OUT_W-1:0] hold_ticks;

  modport source (output valid, output event_res, output hold_ticks, input ready);
  modport sink   (input valid, input event_res, input hold_ticks, output ready);
endinterface

>>> rtl/bdlp_core.sv
// Debounce state, configuration registers and event decision for one tick.
// Depends on bdlp_pkg.
module bdlp_core #(
  parameter int unsigned HOLD_WIDTH  = bdlp_pkg::HOLD_WIDTH_DEF,
  parameter int unsigned QUIET_WIDTH = bdlp_pkg::QUIET_WIDTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [bdlp_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [bdlp_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic                             step_i,
  input  logic                             pin_level_i,
  output logic                             res_valid_o,
  output bdlp_pkg::res_t                   res_o
);
  import bdlp_pkg::*;

  localparam int unsigned LW = (QUIET_WIDTH > DEBOUNCE_W) ? QUIET_WIDTH : DEBOUNCE_W;
  localparam int unsigned CW = (HOLD_WIDTH > HOLD_OUT_W) ? HOLD_WIDTH : HOLD_OUT_W;
  localparam logic [LW-1:0]         QUIET_MAX = LW'({QUIET_WIDTH{1'b1}});
  localparam logic [HOLD_WIDTH-1:0] HOLD_MAX  = {HOLD_WIDTH{1'b1}};
  localparam logic [CW-1:0]         OUT_MAX   = CW'({HOLD_OUT_W{1'b1}});

  logic [DEBOUNCE_W-1:0]  debounce_q;
  logic [LONG_W-1:0]      long_q;
  logic [EDGE_W-1:0]      edge_mode_q;
  logic                   active_low_q;

  logic                   last_level_q, last_level_d;
  logic [QUIET_WIDTH-1:0] quiet_q, quiet_d;
  logic                   armed_q, armed_d;
  logic                   pressed_q, pressed_d;
  logic [HOLD_WIDTH-1:0]  held_q, held_d;

  logic                   rising, falling, retrig, expire, pressed_level;
  logic [DEBOUNCE_W-1:0]  debounce_eff;
  logic [LW-1:0]          load_ext;
  logic [QUIET_WIDTH-1:0] load, quiet_dec;
  logic [HOLD_WIDTH-1:0]  held_inc;
  logic [CW-1:0]          held_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q   <= DEBOUNCE_RST;
      long_q       <= LONG_PRESS_RST;
      edge_mode_q  <= EDGE_MODE_RST;
      active_low_q <= ACTIVE_LOW_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_DEBOUNCE:   debounce_q   <= cfg_wdata_i[DEBOUNCE_W-1:0];
        CFG_LONG_PRESS: long_q       <= cfg_wdata_i[LONG_W-1:0];
        CFG_EDGE_MODE:  edge_mode_q  <= cfg_wdata_i[EDGE_W-1:0];
        CFG_ACTIVE_LOW: active_low_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    held_inc = (pressed_q && held_q != HOLD_MAX) ? held_q + 1'b1 : held_q;
    rising   = !last_level_q && pin_level_i;
    falling  = last_level_q && !pin_level_i;
    unique case (edge_mode_q)
      EDGE_RISE: retrig = rising;
      EDGE_FALL: retrig = falling;
      default:   retrig = rising || falling;
    endcase

    // A zero debounce samples on the next tick; clamp to the counter range
    debounce_eff = (debounce_q == '0) ? DEBOUNCE_W'(1) : debounce_q;
    load_ext     = LW'(debounce_eff);
    load         = (load_ext > QUIET_MAX) ? QUIET_MAX[QUIET_WIDTH-1:0]
                                          : load_ext[QUIET_WIDTH-1:0];
    quiet_dec    = (quiet_q != '0) ? quiet_q - 1'b1 : quiet_q;

    quiet_d = quiet_q;
    armed_d = armed_q;
    expire  = 1'b0;
    if (retrig) begin
      quiet_d = load;
      armed_d = 1'b1;
    end else if (armed_q) begin
      quiet_d = quiet_dec;
      if (quiet_dec == '0) begin
        armed_d = 1'b0;
        expire  = 1'b1;
      end
    end
    last_level_d = pin_level_i;

    pressed_level = !active_low_q;
    held_ext      = CW'(held_inc);
    pressed_d     = pressed_q;
    held_d        = held_inc;
    res_valid_o   = 1'b0;
    res_o.ev      = EV_PRESSED;
    res_o.hold    = '0;
    if (expire) begin
      if (pin_level_i == pressed_level && !pressed_q) begin
        pressed_d   = 1'b1;
        held_d      = '0;
        res_valid_o = 1'b1;
      end else if (pin_level_i != pressed_level && pressed_q) begin
        pressed_d   = 1'b0;
        res_valid_o = 1'b1;
        res_o.ev    = (held_ext > CW'(long_q)) ? EV_LONG : EV_RELEASED;
        res_o.hold  = (held_ext > OUT_MAX) ? OUT_MAX[HOLD_OUT_W-1:0]
                                           : held_ext[HOLD_OUT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_level_q <= 1'b1;
      quiet_q      <= '0;
      armed_q      <= 1'b0;
      pressed_q    <= 1'b0;
      held_q       <= '0;
    end else if (step_i) begin
      last_level_q <= last_level_d;
      quiet_q      <= quiet_d;
      armed_q      <= armed_d;
      pressed_q    <= pressed_d;
      held_q       <= held_d;
    end
  end

endmodule

>>> rtl/bdlp_out_reg.sv
// Result register in front of the output channel; frees the input side
// whenever it is empty or being drained. Depends on bdlp_pkg and bdlp_out_if.
module bdlp_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic             res_valid_i,
  input  bdlp_pkg::res_t   res_i,
  output logic             in_ready_o,
  bdlp_out_if.source       out_o
);
  import bdlp_pkg::*;

  logic valid_q, valid_d;
  res_t res_q;

  assign in_ready_o = !valid_q || out_o.ready;
  assign valid_d    = in_ready_o ? (step_i && res_valid_i) : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Load a new beat only when the slot is free
  always_ff @(posedge clk_i) begin
    if (step_i && res_valid_i && in_ready_o) begin
      res_q <= res_i;
    end
  end

  assign out_o.valid      = valid_q;
  assign out_o.event_res  = res_q.ev;
  assign out_o.hold_ticks = res_q.hold;

endmodule

>>> rtl/button_debounce_long_press.sv
// Button debounce with long-press detection, top level.
// in_i carries one raw pin sample per beat (one beat = one tick). A qualifying
// edge (edge_mode: rising, falling or both) reloads a quiet countdown of
// debounce_ticks; when it runs out the pin is sampled and a press, short
// release or long-press event may be produced on out_o with the saturated
// hold length. Ticks are counted only on accepted input beats.
// Configuration: cfg_we_i writes cfg_wdata_i to register cfg_idx_i
// (0 debounce_ticks, 1 long_press_ticks, 2 edge_mode, 3 active_low);
// write only while no result is pending.
// Throughput: one input beat per cycle while out_o does not stall. An event
// shows on out_o in the cycle after its beat, held in a single result register.
// When out_o stalls with a result pending, in_i.ready drops until it is taken;
// beats that make no event pass through without touching the output.
// Reset: pin treated as released-high, timer disarmed, not pressed, hold zero,
// registers 50 / 1000 / rising only / active low; no result pending.
// Depends on bdlp_pkg, bdlp_in_if, bdlp_out_if, bdlp_core, bdlp_out_reg.
module button_debounce_long_press #(
  parameter int unsigned HOLD_WIDTH  = bdlp_pkg::HOLD_WIDTH_DEF,
  parameter int unsigned QUIET_WIDTH = bdlp_pkg::QUIET_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [bdlp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bdlp_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  bdlp_in_if.sink                         in_i,
  bdlp_out_if.source                      out_o
);
  import bdlp_pkg::*;

  logic in_ready, step, res_valid;
  res_t res;

  assign in_i.ready = in_ready;
  assign step       = in_i.valid && in_ready;

  bdlp_core #(
    .HOLD_WIDTH  (HOLD_WIDTH),
    .QUIET_WIDTH (QUIET_WIDTH)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .step_i      (step),
    .pin_level_i (in_i.pin_level),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  bdlp_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .res_valid_i (res_valid),
    .res_i       (res),
    .in_ready_o  (in_ready),
    .out_o       (out_o)
  );

endmodule
